// File: design/program_stream_audio_demux_top_assert.svh
// Assertion macros shared by the demultiplexer RTL. Each macro expects
// signals named clk and rst_n in the scope where it is used.
`ifndef PROGRAM_STREAM_AUDIO_DEMUX_TOP_ASSERT_SVH
`define PROGRAM_STREAM_AUDIO_DEMUX_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PSAD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psad: same-cycle check failed");
`define PSAD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psad: next-cycle check failed");
`else
`define PSAD_ASSERT_IMP(lbl, ante, cons)
`define PSAD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/psad_pkg.sv
package psad_pkg;

  localparam int NUM_IDS   = 256;
  localparam int ID_W      = 8;
  localparam int HDR_BYTES = 10;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_STREAM_ID = 1'd1;

  localparam logic       AUDIO_ENABLE_RESET = 1'b1;
  localparam logic [7:0] AUDIO_ID_RESET     = 8'hC0;

  localparam logic [7:0] ID_PACK    = 8'hBA;
  localparam logic [7:0] ID_PRIVATE = 8'hBD;
  localparam logic [7:0] ID_VIDEO   = 8'hE0;

  localparam logic [3:0] PACK1_MARK = 4'h2;
  localparam logic [1:0] PACK2_MARK = 2'b01;
  localparam logic [3:0] PACK1_LEN  = 4'd8;
  localparam logic [3:0] PACK2_LEN  = 4'd10;

  localparam logic [15:0] PRIV_MIN_LEN = 16'd15;
  localparam logic [15:0] AUD_HDR_LEN  = 16'd5;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_ID    = 2'd1,
    KIND_PACK  = 2'd2
  } psad_kind_t;

  typedef enum logic [1:0] {
    PACK_UNKNOWN = 2'd0,
    PACK_GEN1    = 2'd1,
    PACK_GEN2    = 2'd2
  } psad_pack_t;

  typedef struct packed {
    logic       audio_enable;
    logic [7:0] audio_stream_id;
  } psad_cfg_t;

  // Result of one parsed byte, before the histogram count is attached.
  typedef struct packed {
    logic        valid;
    psad_kind_t  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  stream_id;
    psad_pack_t  pack_type;
    logic [21:0] mux_rate;
  } psad_res_t;

  typedef struct packed {
    psad_kind_t  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  stream_id;
    logic [31:0] id_count;
    psad_pack_t  pack_type;
    logic [21:0] mux_rate;
  } psad_out_t;

endpackage

// File: design/program_stream_audio_demux_top.sv
// MPEG program stream audio demultiplexer. Takes one stream byte per clock
// unless in_stall holds it off; each result is registered in the parser,
// then goes through a four-entry output queue that lets the input
// keep flowing while the output stalls briefly. After each 00 00 01 start
// code the stream id is reported with its saturating occurrence count; pack
// headers report their generation and mux rate; payload bytes of the
// configured audio stream are passed through. The per-id counts live in a
// 256-entry single-port-write RAM: the id byte addresses the read when it is
// accepted and the incremented count is written back the following cycle.
// Stream ids are at least four bytes apart, so read and write-back of one id
// never overlap. Counts read as zero until first written, tracked by one
// valid bit per id cleared at reset, so no clearing pass is needed.
`include "program_stream_audio_demux_top_assert.svh"

module program_stream_audio_demux_top import psad_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_payload_byte,
  output logic [7:0]           out_stream_id,
  output logic [31:0]          out_id_count,
  output logic [1:0]           out_pack_type,
  output logic [21:0]          out_mux_rate,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1) + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(OUT_DEPTH);

  logic        audio_enable_r;
  logic [7:0]  audio_id_r;
  psad_cfg_t   cfg;
  logic        in_accept;
  psad_res_t   s1;

  logic [COUNT_BITS-1:0] hist_q;
  logic [COUNT_BITS-1:0] cnt_base;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  hist_we;
  logic [NUM_IDS-1:0]    hist_vld_r;

  psad_out_t        fifo_r [OUT_DEPTH];
  psad_out_t        push_data;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [CNT_W-1:0] occ;
  logic             push, pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_enable_r <= AUDIO_ENABLE_RESET;
      audio_id_r     <= AUDIO_ID_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AUDIO_ENABLE:    audio_enable_r <= cfg_data[0];
        REG_AUDIO_STREAM_ID: audio_id_r     <= cfg_data;
      endcase
    end
  end

  assign cfg.audio_enable    = audio_enable_r;
  assign cfg.audio_stream_id = audio_id_r;

  // Every accepted byte may yield one result in s1; hold off the input while
  // the queue plus the result in flight could fill it.
  assign occ       = fifo_cnt_r + CNT_W'(s1.valid);
  assign in_stall  = (occ >= FULL_CNT);
  assign in_accept = in_valid & ~in_stall;

  psad_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_accept),
    .din   (in_byte),
    .cfg   (cfg),
    .res   (s1)
  );

  psad_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_IDS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (s1.stream_id),
    .wdata (cnt_new),
    .re    (in_accept),
    .raddr (in_byte),
    .rdata (hist_q)
  );

  assign hist_we  = s1.valid && s1.kind == KIND_ID;
  assign cnt_base = hist_vld_r[s1.stream_id] ? hist_q : '0;
  assign cnt_new  = (cnt_base == '1) ? cnt_base : cnt_base + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (hist_we) begin
      hist_vld_r[s1.stream_id] <= 1'b1;
    end
  end

  // Output queue.
  assign push = s1.valid;
  assign pop  = out_valid & ~out_stall;

  always_comb begin
    push_data.kind         = s1.kind;
    push_data.payload_byte = s1.payload_byte;
    push_data.stream_id    = s1.stream_id;
    push_data.id_count     = hist_we ? 32'(cnt_new) : '0;
    push_data.pack_type    = s1.pack_type;
    push_data.mux_rate     = s1.mux_rate;
  end

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    if (push && !pop) begin
      fifo_cnt_nxt = fifo_cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      fifo_cnt_nxt = fifo_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid        = (fifo_cnt_r != '0);
  assign out_kind         = fifo_r[rd_ptr_r].kind;
  assign out_payload_byte = fifo_r[rd_ptr_r].payload_byte;
  assign out_stream_id    = fifo_r[rd_ptr_r].stream_id;
  assign out_id_count     = fifo_r[rd_ptr_r].id_count;
  assign out_pack_type    = fifo_r[rd_ptr_r].pack_type;
  assign out_mux_rate     = fifo_r[rd_ptr_r].mux_rate;

  `PSAD_ASSERT_IMP(a_fifo_bound, 1'b1, fifo_cnt_r <= FULL_CNT)
  `PSAD_ASSERT_IMP(a_no_overrun, push && !pop, fifo_cnt_r < FULL_CNT)
  `PSAD_ASSERT_NXT(a_push_shows, push, out_valid)
  `PSAD_ASSERT_NXT(a_count_nonzero, hist_we, hist_vld_r[$past(s1.stream_id)])

endmodule

// File: design/psad_ram.sv
module psad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/psad_parser.sv
`include "program_stream_audio_demux_top_assert.svh"

module psad_parser import psad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic [7:0] din,
  input  psad_cfg_t cfg,
  output psad_res_t res
);

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_ID,
    PH_PACK,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_AUD_HDR,
    PH_AUD_PAY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  zero_run_r, zero_run_nxt;
  logic [7:0]  cur_id_r, cur_id_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  hdr_r [HDR_BYTES];
  logic        hdr_wr;
  psad_res_t   res_r, res_nxt;

  logic [3:0]  idx_inc;
  logic [15:0] len;
  logic [15:0] left_dec;
  logic [3:0]  hidx_dec;

  assign idx_inc  = hdr_idx_r + 4'd1;
  assign len      = {len_hi_r, din};
  assign left_dec = (bytes_left_r != '0) ? bytes_left_r - 16'd1 : bytes_left_r;
  assign hidx_dec = (hdr_idx_r != '0) ? hdr_idx_r - 4'd1 : hdr_idx_r;

  always_comb begin
    phase_nxt      = phase_r;
    zero_run_nxt   = zero_run_r;
    cur_id_nxt     = cur_id_r;
    bytes_left_nxt = bytes_left_r;
    len_hi_nxt     = len_hi_r;
    hdr_idx_nxt    = hdr_idx_r;
    hdr_wr         = 1'b0;
    res_nxt        = '0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (din == 8'h00) begin
          if (zero_run_r != 2'd2) begin
            zero_run_nxt = zero_run_r + 2'd1;
          end
        end else if (din == 8'h01 && zero_run_r == 2'd2) begin
          phase_nxt    = PH_ID;
          zero_run_nxt = '0;
        end else begin
          zero_run_nxt = '0;
        end
      end
      PH_ID: begin
        cur_id_nxt        = din;
        res_nxt.valid     = 1'b1;
        res_nxt.kind      = KIND_ID;
        res_nxt.stream_id = din;
        if (din == ID_PACK) begin
          phase_nxt   = PH_PACK;
          hdr_idx_nxt = '0;
        end else if (din == ID_PRIVATE || din == ID_VIDEO || din == cfg.audio_stream_id) begin
          phase_nxt = PH_LEN_HI;
        end else begin
          phase_nxt    = PH_SEARCH;
          zero_run_nxt = '0;
        end
      end
      PH_PACK: begin
        hdr_wr      = 1'b1;
        hdr_idx_nxt = idx_inc;
        if (idx_inc == 4'd1) begin
          // The first header byte decides the generation; anything else is unknown.
          if (din[7:4] != PACK1_MARK && din[7:6] != PACK2_MARK) begin
            phase_nxt     = PH_SEARCH;
            zero_run_nxt  = '0;
            res_nxt.valid = 1'b1;
            res_nxt.kind  = KIND_PACK;
          end
        end else if (hdr_r[0][7:4] == PACK1_MARK) begin
          if (idx_inc >= PACK1_LEN) begin
            phase_nxt         = PH_SEARCH;
            zero_run_nxt      = '0;
            res_nxt.valid     = 1'b1;
            res_nxt.kind      = KIND_PACK;
            res_nxt.pack_type = PACK_GEN1;
            res_nxt.mux_rate  = {hdr_r[5][6:0], hdr_r[6], din[7:1]};
          end
        end else if (idx_inc >= PACK2_LEN) begin
          phase_nxt         = PH_SEARCH;
          zero_run_nxt      = '0;
          res_nxt.valid     = 1'b1;
          res_nxt.kind      = KIND_PACK;
          res_nxt.pack_type = PACK_GEN2;
          res_nxt.mux_rate  = {hdr_r[6], hdr_r[7], hdr_r[8][7:2]};
        end
      end
      PH_LEN_HI: begin
        len_hi_nxt = din;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (cur_id_r == ID_PRIVATE) begin
          bytes_left_nxt = (len < PRIV_MIN_LEN) ? PRIV_MIN_LEN : len;
          phase_nxt      = PH_SKIP;
        end else if (cur_id_r == ID_VIDEO) begin
          bytes_left_nxt = len;
          if (len == '0) begin
            phase_nxt    = PH_SEARCH;
            zero_run_nxt = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else begin
          bytes_left_nxt = (len < AUD_HDR_LEN) ? '0 : len - AUD_HDR_LEN;
          hdr_idx_nxt    = AUD_HDR_LEN[3:0];
          phase_nxt      = PH_AUD_HDR;
        end
      end
      PH_SKIP: begin
        bytes_left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt    = PH_SEARCH;
          zero_run_nxt = '0;
        end
      end
      PH_AUD_HDR: begin
        hdr_idx_nxt = hidx_dec;
        if (hidx_dec == '0) begin
          if (bytes_left_r == '0) begin
            phase_nxt    = PH_SEARCH;
            zero_run_nxt = '0;
          end else begin
            phase_nxt = PH_AUD_PAY;
          end
        end
      end
      PH_AUD_PAY: begin
        bytes_left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt    = PH_SEARCH;
          zero_run_nxt = '0;
        end
        res_nxt.valid        = cfg.audio_enable;
        res_nxt.kind         = KIND_AUDIO;
        res_nxt.payload_byte = din;
      end
      default: begin
        phase_nxt    = PH_SEARCH;
        zero_run_nxt = '0;
      end
    endcase
    res_nxt.valid = res_nxt.valid & step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEARCH;
      zero_run_r   <= '0;
      bytes_left_r <= '0;
      hdr_idx_r    <= '0;
      res_r        <= '0;
    end else begin
      res_r <= res_nxt;
      if (step) begin
        phase_r      <= phase_nxt;
        zero_run_r   <= zero_run_nxt;
        bytes_left_r <= bytes_left_nxt;
        hdr_idx_r    <= hdr_idx_nxt;
        cur_id_r     <= cur_id_nxt;
        len_hi_r     <= len_hi_nxt;
        if (hdr_wr) begin
          hdr_r[hdr_idx_r] <= din;
        end
      end
    end
  end

  assign res = res_r;

  `PSAD_ASSERT_NXT(a_res_needs_step, !step, !res_r.valid)
  `PSAD_ASSERT_NXT(a_phase_holds, !step, $stable(phase_r) && $stable(bytes_left_r))
  `PSAD_ASSERT_IMP(a_unknown_pack_zero, res_r.valid && res_r.pack_type == PACK_UNKNOWN, res_r.mux_rate == '0)

endmodule
